// ===== rtl/core/rar_pkg.sv =====
// Shared types and constants for the rational arithmetic reduce core.
package rar_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int NUM_W = 33;
    localparam int DEN_W = 32;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE, S_EUC, S_DIVN, S_DIVD, S_OUT
    } t_bstate;

endpackage

// ===== rtl/core/rational_arith_reduce_core.sv =====
// Top level of the rational arithmetic reduce core.
//  channel | dir | handshake           | payload
//  in      | in  | i_valid / o_stall   | i_operation, i_a_num, i_a_den, i_b_num, i_b_den
//  out     | out | o_valid / i_stall   | o_res_num, o_res_den, o_div_error
// One item holds the back end from accept until its result is registered: the
// Euclid loop and then the numerator and denominator divisions all run on the
// one bit-serial restoring divider, on 2*OPERAND_WIDTH+1 bit magnitudes.
// A zero denominator skips the divider and goes straight to the output state.
// Synchronous active-low reset clears all control state.
// A two-entry queue between front and back lets input keep flowing while
// the back end works or the output is stalled.
module rational_arith_reduce_core #(
    parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  logic [1:0] i_operation,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_den,
    output logic o_valid,
    input  logic i_stall,
    output logic signed [rar_pkg::NUM_W-1:0] o_res_num,
    output logic signed [rar_pkg::DEN_W-1:0] o_res_den,
    output logic o_div_error
);
    import rar_pkg::*;

    localparam int MW = 2 * OPERAND_WIDTH + 1;

    logic q_valid, q_take, q_nneg, q_dneg;
    logic [MW-1:0] q_nmag, q_dmag;

    rar_front #(.OW(OPERAND_WIDTH), .MW(MW)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_operation,
        .i_a_num, .i_a_den, .i_b_num, .i_b_den,
        .o_q_valid(q_valid), .i_q_take(q_take), .o_q_nneg(q_nneg),
        .o_q_dneg(q_dneg), .o_q_nmag(q_nmag), .o_q_dmag(q_dmag)
    );

    rar_back #(.OW(OPERAND_WIDTH), .MW(MW)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_take(q_take),
        .i_q_nneg(q_nneg), .i_q_dneg(q_dneg), .i_q_nmag(q_nmag),
        .i_q_dmag(q_dmag), .o_valid, .i_stall, .o_res_num, .o_res_den,
        .o_div_error
    );
endmodule

// ===== rtl/core/rar_front.sv =====
// Front end: products, signed sum and magnitude split, into a two-deep queue.
module rar_front #(
    parameter int OW = rar_pkg::OPERAND_WIDTH_DEF,
    parameter int MW = 2 * OW + 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_operation,
    input  logic signed [OW-1:0] i_a_num,
    input  logic signed [OW-1:0] i_a_den,
    input  logic signed [OW-1:0] i_b_num,
    input  logic signed [OW-1:0] i_b_den,
    output logic                o_q_valid,
    input  logic                i_q_take,
    output logic                o_q_nneg,
    output logic                o_q_dneg,
    output logic [MW-1:0]       o_q_nmag,
    output logic [MW-1:0]       o_q_dmag
);
    import rar_pkg::*;

    localparam int PW = 2 * OW;

    // stage 1: products
    logic                r_s1_v;
    logic                r_s1_sub;
    logic                r_s1_two;
    logic signed [PW-1:0] r_p, r_q, r_d;
    // queue
    logic [1:0]          r_qv, n_qv;
    logic [MW-1:0]       r_nm [2];
    logic [MW-1:0]       r_dm [2];
    logic [1:0]          r_nn, r_dn;
    logic                r_wp, r_rp;

    logic                s1_adv, q_push, q_full, q_pop;
    logic signed [PW:0]  p_x, q_x, sum;
    logic                nneg;
    logic [MW-1:0]       nmag;
    logic [MW-1:0]       dmag;
    logic signed [PW:0]  d_x;

    assign q_full = r_qv[0] & r_qv[1];
    assign q_push = r_s1_v & ~q_full;
    assign q_pop  = i_q_take & o_q_valid;
    assign s1_adv = ~r_s1_v | q_push;
    assign o_stall = ~s1_adv;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            unique case (t_op'(i_operation))
                OP_ADD, OP_SUB: begin
                    r_p <= PW'(i_a_num) * PW'(i_b_den);
                    r_q <= PW'(i_b_num) * PW'(i_a_den);
                    r_d <= PW'(i_a_den) * PW'(i_b_den);
                end
                OP_MUL: begin
                    r_p <= PW'(i_a_num) * PW'(i_b_num);
                    r_q <= '0;
                    r_d <= PW'(i_a_den) * PW'(i_b_den);
                end
                default: begin
                    r_p <= PW'(i_a_num) * PW'(i_b_den);
                    r_q <= '0;
                    r_d <= PW'(i_a_den) * PW'(i_b_num);
                end
            endcase
            r_s1_sub <= (i_operation == OP_SUB);
            r_s1_two <= 1'b1;
        end
    end

    assign p_x = {r_p[PW-1], r_p};
    assign q_x = {r_q[PW-1], r_q};
    assign sum = r_s1_sub ? (p_x - q_x) : (p_x + q_x);
    assign nneg = sum[PW];
    assign nmag = nneg ? MW'(-sum) : MW'(sum);
    assign d_x = {r_d[PW-1], r_d};
    assign dmag = d_x[PW] ? MW'(-d_x) : MW'(d_x);

    // push and pop never touch the same entry: a full queue blocks the push
    always_comb begin
        n_qv = r_qv;
        if (q_pop) n_qv[r_rp] = 1'b0;
        if (q_push) n_qv[r_wp] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_qv   <= '0;
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
        end else begin
            if (s1_adv) r_s1_v <= i_valid;
            r_qv <= n_qv;
            if (q_push) r_wp <= ~r_wp;
            if (q_pop) r_rp <= ~r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_nm[r_wp] <= nmag;
            r_dm[r_wp] <= dmag;
            r_nn[r_wp] <= nneg & r_s1_two;
            r_dn[r_wp] <= d_x[PW];
        end
    end

    assign o_q_valid = r_qv[r_rp];
    assign o_q_nneg  = r_nn[r_rp];
    assign o_q_dneg  = r_dn[r_rp];
    assign o_q_nmag  = r_nm[r_rp];
    assign o_q_dmag  = r_dm[r_rp];
endmodule

// ===== rtl/core/rar_back.sv =====
// Back end: Euclid loop and final divisions on a shared restoring divider.
module rar_back #(
    parameter int OW = rar_pkg::OPERAND_WIDTH_DEF,
    parameter int MW = 2 * OW + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    output logic          o_q_take,
    input  logic          i_q_nneg,
    input  logic          i_q_dneg,
    input  logic [MW-1:0] i_q_nmag,
    input  logic [MW-1:0] i_q_dmag,
    output logic          o_valid,
    input  logic          i_stall,
    output logic signed [rar_pkg::NUM_W-1:0] o_res_num,
    output logic signed [rar_pkg::DEN_W-1:0] o_res_den,
    output logic          o_div_error
);
    import rar_pkg::*;

    localparam int CW = $clog2(MW + 1);

    t_bstate r_st, n_st;
    logic [MW-1:0] r_x, r_y, r_nm, r_dm, r_nq;
    logic          r_nn, r_dn, r_par;
    // divider
    logic [MW-1:0] r_rem, r_quo, r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [MW:0]   trial;
    logic          dv_done;
    logic          r_ov;
    logic signed [NUM_W-1:0] r_on;
    logic signed [DEN_W-1:0] r_od;
    logic          r_oe;

    logic start_div;
    logic [MW-1:0] div_a, div_b;
    logic          g_neg, nz;

    assign trial   = {r_rem, r_quo[MW-1]} - {1'b0, r_dvs};
    assign dv_done = r_busy && (r_cnt == CW'(MW - 1));
    assign g_neg   = r_par ? r_dn : r_nn;
    assign o_q_take = (r_st == S_IDLE) && i_q_valid;

    always_comb begin
        n_st = r_st;
        start_div = 1'b0;
        div_a = r_x;
        div_b = r_y;
        unique case (r_st)
            S_IDLE: if (i_q_valid) n_st = (i_q_dmag == '0) ? S_OUT : S_EUC;
            S_EUC: begin
                if (!r_busy) begin
                    if (r_y == '0) begin
                        n_st = S_DIVN;
                        start_div = 1'b1;
                        div_a = r_nm;
                        div_b = r_x;
                    end else begin
                        start_div = 1'b1;
                    end
                end
            end
            S_DIVN: if (dv_done) begin
                n_st = S_DIVD;
            end
            S_DIVD: if (!r_busy && r_cnt == '0) begin
                start_div = 1'b1;
                div_a = r_dm;
                div_b = r_x;
            end else if (dv_done) begin
                n_st = S_OUT;
            end
            S_OUT: if (!r_ov || !i_stall) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_st <= n_st;
            if (start_div) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (dv_done) begin
                r_busy <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_st == S_OUT && (!r_ov || !i_stall)) r_ov <= 1'b1;
            else if (r_ov && !i_stall) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_div) begin
            r_rem <= '0;
            r_quo <= div_a;
            r_dvs <= div_b;
        end else if (r_busy) begin
            if (!trial[MW]) begin
                r_rem <= trial[MW-1:0];
                r_quo <= {r_quo[MW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[MW-2:0], r_quo[MW-1]};
                r_quo <= {r_quo[MW-2:0], 1'b0};
            end
        end
        if (r_st == S_IDLE && i_q_valid) begin
            r_x   <= i_q_nmag;
            r_y   <= i_q_dmag;
            r_nm  <= i_q_nmag;
            r_dm  <= i_q_dmag;
            r_nn  <= i_q_nneg;
            r_dn  <= i_q_dneg;
            r_par <= 1'b0;
        end
        if (r_st == S_EUC && dv_done) begin
            r_x   <= r_y;
            r_y   <= trial[MW] ? {r_rem[MW-2:0], r_quo[MW-1]} : trial[MW-1:0];
            r_par <= ~r_par;
        end
        if (r_st == S_DIVN && dv_done)
            r_nq <= trial[MW] ? {r_quo[MW-2:0], 1'b0} : {r_quo[MW-2:0], 1'b1};
        if (r_st == S_DIVD && dv_done) begin
            r_dm <= trial[MW] ? {r_quo[MW-2:0], 1'b0} : {r_quo[MW-2:0], 1'b1};
            r_nm <= r_nq;
        end
        if (r_st == S_OUT && (!r_ov || !i_stall)) begin
            if (r_dm == '0) begin
                r_on <= '0;
                r_od <= '0;
                r_oe <= 1'b1;
            end else begin
                r_on <= (r_nn != g_neg && nz) ? NUM_W'(-r_nm) : NUM_W'(r_nm);
                r_od <= (r_dn != g_neg) ? DEN_W'(-r_dm) : DEN_W'(r_dm);
                r_oe <= 1'b0;
            end
        end
    end

    assign nz = (r_nm != '0);
    assign o_valid     = r_ov;
    assign o_res_num   = r_on;
    assign o_res_den   = r_od;
    assign o_div_error = r_oe;
endmodule

// ===== verif/tb.sv =====
// Testbench for rational_arith_reduce_core: directed and random fraction operations
`timescale 1ns / 1ps

module tb;
    import rar_pkg::*;

    localparam int OW = OPERAND_WIDTH_DEF;
    localparam int STALL_LIMIT = 40000;
    localparam int HOLD_CYCLES = 3000;

    typedef struct packed {
        logic signed [NUM_W-1:0] num;
        logic signed [DEN_W-1:0] den;
        logic                    err;
    } t_fraction_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    logic [1:0] i_operation;
    logic signed [OW-1:0] i_a_num, i_a_den, i_b_num, i_b_den;
    logic o_valid;
    logic i_stall;
    logic signed [NUM_W-1:0] o_res_num;
    logic signed [DEN_W-1:0] o_res_den;
    logic o_div_error;

    t_fraction_result reduced_q[$];
    int fail_cnt = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_len = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int quiet_cycles = 0;

    rational_arith_reduce_core #(.OPERAND_WIDTH(OW)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_operation(i_operation),
        .i_a_num(i_a_num), .i_a_den(i_a_den), .i_b_num(i_b_num), .i_b_den(i_b_den),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_res_num(o_res_num), .o_res_den(o_res_den), .o_div_error(o_div_error)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Cross products reduced by a truncating-remainder Euclid divisor.
    function automatic t_fraction_result reduce_fraction(t_op op,
            logic signed [OW-1:0] an, logic signed [OW-1:0] ad,
            logic signed [OW-1:0] bn, logic signed [OW-1:0] bd);
        longint n, d;
        longint unsigned nm, dm, x, y, t;
        int steps;
        bit nn, dn, gn;
        t_fraction_result r;
        case (op)
            OP_ADD: n = longint'(an) * longint'(bd) + longint'(bn) * longint'(ad);
            OP_SUB: n = longint'(an) * longint'(bd) - longint'(bn) * longint'(ad);
            OP_MUL: n = longint'(an) * longint'(bn);
            default: n = longint'(an) * longint'(bd);
        endcase
        d = (op == OP_DIV) ? longint'(ad) * longint'(bn) : longint'(ad) * longint'(bd);
        nn = n < 0;
        dn = d < 0;
        nm = nn ? -n : n;
        dm = dn ? -d : d;
        if (dm == 0) begin
            r.num = '0;
            r.den = '0;
            r.err = 1'b1;
            return r;
        end
        x = nm;
        y = dm;
        steps = 0;
        while (y != 0) begin
            t = y;
            y = x % y;
            x = t;
            steps++;
        end
        // remainder signs alternate with the step count
        gn = steps[0] ? dn : nn;
        nm = nm / x;
        dm = dm / x;
        r.num = NUM_W'((nn != gn && nm != 0) ? -nm : nm);
        r.den = DEN_W'((dn != gn) ? -dm : dm);
        r.err = 1'b0;
        return r;
    endfunction

    task automatic send_item(t_op op, logic signed [OW-1:0] an, logic signed [OW-1:0] ad,
                             logic signed [OW-1:0] bn, logic signed [OW-1:0] bd);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_a_num     <= an;
        i_a_den     <= ad;
        i_b_num     <= bn;
        i_b_den     <= bd;
        do @(posedge i_clk); while (o_stall);
        reduced_q.push_back(reduce_fraction(op, an, ad, bn, bd));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (reduced_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [OW-1:0] rand_operand();
        case ($urandom_range(5))
            0: return OW'($urandom_range(8) - 4);
            1: return OW'($urandom_range(60) - 30);
            2: return {1'b1, {(OW-1){1'b0}}};
            3: return {1'b0, {(OW-1){1'b1}}};
            default: return OW'($urandom);
        endcase
    endfunction

    task automatic test_extremes();
        logic [OW-1:0] mn, mx;
        mn = {1'b1, {(OW-1){1'b0}}};
        mx = {1'b0, {(OW-1){1'b1}}};
        send_item(OP_ADD, mx, mx, mx, mx);
        send_item(OP_SUB, mn, mx, mx, mn);
        send_item(OP_MUL, mn, mn, mn, mn);
        send_item(OP_DIV, mn, mx, mx, mn);
        send_item(OP_ADD, mn, mn, mn, mn);
        send_item(OP_SUB, -1, -1, 1, 1);
    endtask

    task automatic test_ops();
        t_op op;
        for (int k = 0; k < 4; k++) begin
            op = t_op'(k);
            send_item(op, 3, 4, -5, 6);
            send_item(op, -7, -9, 2, -3);
        end
    endtask

    task automatic test_special();
        send_item(OP_DIV, 1, 2, 0, 5);   // zero divisor fraction
        send_item(OP_ADD, 1, 0, 1, 3);   // zero left denominator
        send_item(OP_MUL, 4, 3, 2, 0);   // zero right denominator
        send_item(OP_SUB, 2, 3, 2, 3);   // zero numerator
        send_item(OP_MUL, 0, -5, 7, 9);  // zero numerator, negative denominator
        send_item(OP_ADD, 6, -4, 3, -2); // negative denominators
        send_item(OP_DIV, -6, 4, -3, 2);
    endtask

    task automatic test_random(int count);
        t_op op;
        for (int k = 0; k < count; k++) begin
            op = t_op'($urandom_range(3));
            send_item(op, rand_operand(), rand_operand(), rand_operand(), rand_operand());
        end
    endtask

    task automatic test_backpressure();
        hold_req++;
        test_random(12);
        wait_drained();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_operation <= '0;
        i_a_num     <= '0;
        i_a_den     <= '0;
        i_b_num     <= '0;
        i_b_den     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_ops();
        test_special();
        wait_drained();
        test_backpressure();
        send_idle_pct = 9;
        recv_idle_pct = 62;
        test_random(620);
        wait_drained();
        send_idle_pct = 62;
        recv_idle_pct = 9;
        test_random(620);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(620);
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // receiver: a long hold starts when the test asks for one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_len  <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_len > 0) begin
            hold_len <= hold_len - 1;
            i_stall  <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_fraction_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (reduced_q.size() == 0) begin
                $error("result transaction with nothing expected");
                fail_cnt++;
            end else begin
                exp_r = reduced_q.pop_front();
                if (o_res_num !== exp_r.num) begin
                    $error("res_num expected %0d got %0d", exp_r.num, o_res_num);
                    fail_cnt++;
                end
                if (o_res_den !== exp_r.den) begin
                    $error("res_den expected %0d got %0d", exp_r.den, o_res_den);
                    fail_cnt++;
                end
                if (o_div_error !== exp_r.err) begin
                    $error("div_error expected %0b got %0b", exp_r.err, o_div_error);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
